### hdl/bihp_pkg.sv
// Shared types and constants for the bitmap info header parser.
// No dependencies; imported by every module in hdl/.
package bihp_pkg;

    localparam int BYTE_W     = 8;
    localparam int POS_W      = 6;
    localparam int HDR_FULL   = 40;
    localparam int HDR_CORE   = 12;
    localparam int SIZE_BYTES = 4;

    // Bit-count codes that get a computed image size
    localparam logic [15:0] BPP_1 = 16'd1;
    localparam logic [15:0] BPP_4 = 16'd4;
    localparam logic [15:0] BPP_8 = 16'd8;

    typedef struct packed {
        logic [31:0] header_size;
        logic [31:0] width;
        logic [31:0] height;
        logic [15:0] planes;
        logic [15:0] bit_count;
        logic [31:0] compression;
        logic [31:0] size_image;
        logic [31:0] x_pels_per_meter;
        logic [31:0] y_pels_per_meter;
        logic [31:0] colors_used;
        logic [31:0] colors_important;
        logic        bad_size;
    } hdr_fields_t;

    // Parser to size stage: decoded fields plus the pending size product
    typedef struct packed {
        hdr_fields_t fields;
        logic        calc_size;
        logic [31:0] row_bytes;
    } bihp_mid_t;

endpackage

### hdl/bihp_parse.sv
// Byte collector and field decoder: input register, byte position, header bytes,
// decoded result register. Depends on bihp_pkg.
module bihp_parse import bihp_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic [BYTE_W-1:0]  s_byte,
    input  logic               s_start,
    output logic               s_ready,
    input  logic               dn_ready,
    output logic               mid_valid,
    output bihp_mid_t          mid
);

    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_start_reg;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [BYTE_W-1:0] store_reg [HDR_FULL];
    logic [BYTE_W-1:0] view [HDR_FULL];
    logic              mid_valid_reg, mid_valid_next;
    bihp_mid_t         mid_reg, mid_next;

    logic              mid_adv, fire, take, bad, done, emit, full;
    logic [POS_W-1:0]  wpos, pos_inc;
    logic [31:0]       size_w, w, h, comp;
    logic [15:0]       bits;
    logic [32:0]       wsum;
    logic [5:0]        round_add;
    hdr_fields_t       f;

    assign mid_adv   = !mid_valid_reg || dn_ready;
    assign s_ready   = !in_valid_reg || mid_adv;
    assign fire      = in_valid_reg && mid_adv;
    assign mid_valid = mid_valid_reg;
    assign mid       = mid_reg;

    always_comb begin
        take    = in_start_reg || (pos_reg != '0 && pos_reg < POS_W'(HDR_FULL));
        wpos    = in_start_reg ? '0 : pos_reg;
        pos_inc = wpos + POS_W'(1);
        for (int i = 0; i < HDR_FULL; i++) begin
            view[i] = (take && wpos == POS_W'(i)) ? in_byte_reg : store_reg[i];
        end
        size_w = {view[3], view[2], view[1], view[0]};
        bad    = pos_inc == POS_W'(SIZE_BYTES) && size_w != 32'(HDR_FULL)
                 && size_w != 32'(HDR_CORE);
        done   = pos_inc >= POS_W'(SIZE_BYTES) && size_w == {26'd0, pos_inc};
        emit   = take && (bad || done);
        full   = size_w == 32'(HDR_FULL);

        f = '0;
        f.header_size = size_w;
        if (full) begin
            f.width            = {view[7], view[6], view[5], view[4]};
            f.height           = {view[11], view[10], view[9], view[8]};
            f.planes           = {view[13], view[12]};
            f.bit_count        = {view[15], view[14]};
            f.compression      = {view[19], view[18], view[17], view[16]};
            f.size_image       = {view[23], view[22], view[21], view[20]};
            f.x_pels_per_meter = {view[27], view[26], view[25], view[24]};
            f.y_pels_per_meter = {view[31], view[30], view[29], view[28]};
            f.colors_used      = {view[35], view[34], view[33], view[32]};
            f.colors_important = {view[39], view[38], view[37], view[36]};
        end else begin
            // core header: 16-bit fields; the other fields start at zero
            f.width     = {16'd0, view[5], view[4]};
            f.height    = {16'd0, view[7], view[6]};
            f.planes    = {view[9], view[8]};
            f.bit_count = {view[11], view[10]};
        end

        w    = f.width;
        h    = f.height;
        comp = f.compression;
        bits = f.bit_count;

        mid_next           = '0;
        mid_next.calc_size = 1'b0;
        // ceil(width / pixels per 32-bit word) words, four bytes each
        priority if (bits == BPP_1) begin
            round_add = 6'd31;
        end else if (bits == BPP_4) begin
            round_add = 6'd7;
        end else begin
            round_add = 6'd3;
        end
        wsum = {1'b0, w} + {27'd0, round_add};
        priority if (bits == BPP_1) begin
            mid_next.row_bytes = 32'({wsum[32:5], 2'b00});
        end else if (bits == BPP_4) begin
            mid_next.row_bytes = {wsum[32:3], 2'b00};
        end else begin
            mid_next.row_bytes = 32'({wsum[32:2], 2'b00});
        end
        if (comp == '0) begin
            priority if (bits == BPP_1) begin
                mid_next.calc_size = 1'b1;
                f.colors_used      = 32'd2;
                f.colors_important = 32'd2;
            end else if (bits == BPP_4) begin
                mid_next.calc_size = 1'b1;
                f.colors_used      = 32'd0;
                f.colors_important = 32'd16;
            end else if (bits == BPP_8) begin
                mid_next.calc_size = 1'b1;
                f.colors_used      = 32'd0;
                f.colors_important = 32'd256;
            end else begin
                mid_next.calc_size = 1'b0;
            end
        end

        if (bad) begin
            f                  = '0;
            f.header_size      = size_w;
            f.bad_size         = 1'b1;
            mid_next.calc_size = 1'b0;
        end
        mid_next.fields = f;

        pos_next = pos_reg;
        if (fire && take) begin
            pos_next = emit ? '0 : pos_inc;
        end
        mid_valid_next = mid_valid_reg;
        if (mid_adv) begin
            mid_valid_next = fire && emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            pos_reg       <= '0;
            mid_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            pos_reg       <= pos_next;
            mid_valid_reg <= mid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg  <= s_byte;
            in_start_reg <= s_start;
        end
        if (fire && take) begin
            store_reg[wpos] <= in_byte_reg;
        end
        if (fire && emit) begin
            mid_reg <= mid_next;
        end
    end

endmodule

### hdl/bihp_size.sv
// Image size multiply and result register.
// Depends on bihp_pkg.
module bihp_size import bihp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        mid_valid,
    input  bihp_mid_t   mid,
    output logic        dn_ready,
    output logic        m_valid,
    input  logic        m_ready,
    output hdr_fields_t out_fields
);

    logic        out_valid_reg;
    hdr_fields_t out_reg, out_next;
    logic [31:0] prod;

    assign dn_ready   = !out_valid_reg || m_ready;
    assign m_valid    = out_valid_reg;
    assign out_fields = out_reg;

    // product wraps modulo 2^32
    assign prod = mid.row_bytes * mid.fields.height;

    always_comb begin
        out_next = mid.fields;
        if (mid.calc_size) begin
            out_next.size_image = prod;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (dn_ready) begin
            out_valid_reg <= mid_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (dn_ready && mid_valid) begin
            out_reg <= out_next;
        end
    end

endmodule

### hdl/bmp_info_header_parser.sv
// Top level of the bitmap info header parser: stream ports and result packing.
// Depends on bihp_pkg, bihp_parse, bihp_size.
//
//  channel | dir | tdata                              | tuser
//  s_      | in  | data_byte                          | start_req
//  m_      | out | ten header fields + header_size    | bad_size
//
// One header byte per cycle while s_tready is high; no configuration.
// After the transfer of the header's last byte, a result passes through the input register,
// the decode register and the multiply/result register before it leaves.
// Reset clears the byte position and all valid flags; header bytes are not cleared.
// An output stall is absorbed by the empty stages before s_tready drops.
module bmp_info_header_parser import bihp_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] data_byte
    input  logic         s_tuser,   // [0] start_req
    output logic         m_tvalid,
    input  logic         m_tready,
    // [31:0] header_size, [63:32] width, [95:64] height, [111:96] planes,
    // [127:112] bit_count, [159:128] compression, [191:160] size_image,
    // [223:192] x_pels_per_meter, [255:224] y_pels_per_meter,
    // [287:256] colors_used, [319:288] colors_important
    output logic [319:0] m_tdata,
    output logic         m_tuser    // [0] bad_size
);

    logic        mid_valid, dn_ready;
    bihp_mid_t   mid;
    hdr_fields_t res;

    bihp_parse u_parse (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_tvalid),
        .s_byte    (s_tdata),
        .s_start   (s_tuser),
        .s_ready   (s_tready),
        .dn_ready  (dn_ready),
        .mid_valid (mid_valid),
        .mid       (mid)
    );

    bihp_size u_size (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .mid_valid  (mid_valid),
        .mid        (mid),
        .dn_ready   (dn_ready),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .out_fields (res)
    );

    assign m_tdata = {res.colors_important, res.colors_used, res.y_pels_per_meter,
                      res.x_pels_per_meter, res.size_image, res.compression,
                      res.bit_count, res.planes, res.height, res.width,
                      res.header_size};
    assign m_tuser = res.bad_size;

    // input only backs up when every stage is full and the output stalls
    a_stall_source: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output backpressure");

    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res.bad_size |-> res.width == '0 && res.height == '0
            && res.size_image == '0 && res.colors_important == '0
            && res.header_size != 32'(HDR_FULL) && res.header_size != 32'(HDR_CORE))
        else $error("bad-size result carries field data");

    a_good_size: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !res.bad_size |->
            res.header_size == 32'(HDR_FULL) || res.header_size == 32'(HDR_CORE))
        else $error("result with unexpected header size");

    a_core_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res.header_size == 32'(HDR_CORE) |->
            res.compression == '0 && res.x_pels_per_meter == '0
            && res.y_pels_per_meter == '0 && res.width[31:16] == '0)
        else $error("core header result has extended fields");

endmodule
